>>> rtl/additive_harmonic_oscillator_bank_unit_macros.svh
// Assertion macros for the additive oscillator bank.
`ifndef ADDITIVE_HARMONIC_OSCILLATOR_BANK_UNIT_MACROS_SVH
`define ADDITIVE_HARMONIC_OSCILLATOR_BANK_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define AHOB_ASSERT_IMPL(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define AHOB_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);
`else
`define AHOB_ASSERT_IMPL(label, ck, rs, ante, cons, msg)
`define AHOB_ASSERT_NEXT(label, ck, rs, ante, cons, msg)
`endif

`endif

>>> rtl/ahob_pkg.sv
// Shared types and constants of the additive oscillator bank.
package ahob_pkg;

  localparam int FREQ_W   = 16;
  localparam int AMP_W    = 16;
  localparam int SAMPLE_W = 24;
  localparam int BASE_W   = 32;
  localparam int WAVE_W   = 2;
  localparam int HCOUNT_W = 7;
  localparam int GAIN_W   = 16;
  localparam int PHASE_W  = 32;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  typedef enum logic [WAVE_W-1:0] {
    WAVE_TRIANGLE = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_SAW_RISE = 2'd2,
    WAVE_SAW_FALL = 2'd3
  } wave_t;

  typedef enum logic [1:0] {
    REG_BASE_INC = 2'd0,
    REG_WAVEFORM = 2'd1,
    REG_HCOUNT   = 2'd2,
    REG_GAIN     = 2'd3
  } reg_idx_t;

  localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;

  // sine table build: 2*pi in Q30 and the Taylor term divisors (2n)(2n+1)
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                              64'd110, 64'd156, 64'd210};

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

  // datapath widths
  localparam int RECIP_W  = 33;  // floor(2^32/d), d >= 1
  localparam int WEIGHT_W = 25;  // normalized weight, at most 2^24
  localparam int TOTAL_W  = 36;  // sum of reciprocals over up to 256 harmonics
  localparam int MUL_A_W  = 33;
  localparam int MUL_B_W  = 26;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W    = 50;

endpackage

>>> rtl/ahob_if.sv
// Stream channels of the additive oscillator bank: tick input and sample output.
interface ahob_in_if;
  import ahob_pkg::*;
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] freq_factor;
  logic [AMP_W-1:0]  amp_factor;
  logic              restart;
  modport source (output valid, freq_factor, amp_factor, restart, input ready);
  modport sink (input valid, freq_factor, amp_factor, restart, output ready);
endinterface

interface ahob_out_if;
  import ahob_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

>>> rtl/additive_harmonic_oscillator_bank_unit.sv
// Additive oscillator bank: sine harmonics summed into a band-limited waveform.
//
//   channel   kind             payload                           transaction
//   ctrl      stream in        freq_factor, amp_factor, restart  valid && ready
//   audio     stream out       sample                            valid && ready
//   apb       register port    paddr[3:2] selects register       psel&&penable&&pwrite
//
// One shared multiplier serves the fundamental step, phase indexing, interpolation,
// weighting and the gains, 7 steps per harmonic over the n active harmonics.
// After reset and after any write of waveform or harmonic_count the weight table is
// rebuilt by a restoring divider, one quotient bit a cycle, while ctrl is not ready.
// Reset is synchronous; the audio register holds a result until taken, and the next
// tick is accepted meanwhile, stalling only at its own finish.
`include "additive_harmonic_oscillator_bank_unit_macros.svh"

module additive_harmonic_oscillator_bank_unit #(
  parameter int MAX_HARMONICS   = 64,
  parameter int SINE_TABLE_SIZE = 2048
) (
  input  logic                            clk,
  input  logic                            rst,
  ahob_in_if.sink                         ctrl,
  ahob_out_if.source                      audio,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ahob_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ahob_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ahob_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import ahob_pkg::*;

  localparam int KIW = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
  localparam int KW  = $clog2(MAX_HARMONICS + 1);
  localparam int MW  = $clog2(2 * MAX_HARMONICS);
  localparam int DW  = 2 * MW;
  localparam int IW  = $clog2(SINE_TABLE_SIZE);
  localparam int HW  = (KW > HCOUNT_W) ? KW : HCOUNT_W;
  localparam int CW  = $clog2(RECIP_W + 1);

  typedef logic signed [SAMPLE_W-1:0] sine_rom_t [SINE_TABLE_SIZE];

  // quarter-wave Taylor series, folded to a full turn, rounded to Q23
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t          rom;
    logic [63:0]        t;
    logic [63:0]        r;
    logic [63:0]        q;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    logic [1:0]         quad;
    for (int i = 0; i < SINE_TABLE_SIZE; i++) begin
      t    = (64'(i) << 32) / SINE_TABLE_SIZE;
      quad = t[31:30];
      r    = t & 64'h3FFF_FFFF;
      q    = quad[0] ? (64'h4000_0000 - r) : r;
      x    = (q * TWO_PI_Q30) >> 32;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
        if (n % 2 == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (sum + 64) >>> 7;
      if (v > 64'sd8388607) begin
        v = 64'sd8388607;
      end
      if (quad[1]) begin
        v = -v;
      end
      rom[i] = v[SAMPLE_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_W_INIT,
    ST_W_LOAD1,
    ST_W_DIV1,
    ST_W_STORE1,
    ST_W_READ2,
    ST_W_LOAD2,
    ST_W_DIV2,
    ST_W_STORE2,
    ST_FUND,
    ST_FUND_LATCH,
    ST_H_READ,
    ST_H_PMUL,
    ST_H_ROMA,
    ST_H_ROMB,
    ST_H_IMUL,
    ST_H_WMUL,
    ST_H_ACC,
    ST_O_SCALE,
    ST_O_GAIN,
    ST_O_AMP,
    ST_O_DONE
  } state_t;

  // configuration
  logic [BASE_W-1:0]   base_inc;
  wave_t               waveform;
  logic [HCOUNT_W-1:0] hcount;
  logic [GAIN_W-1:0]   gain;

  logic     cfg_wr;
  reg_idx_t cfg_idx;
  logic     rebuild_wr;

  // control
  state_t                   state;
  logic                     dirty;
  logic                     out_valid;
  logic [MAX_HARMONICS-1:0] phase_valid;
  logic [PHASE_W-1:0]       phase_start;

  // payload
  logic [FREQ_W-1:0]          ff_q;
  logic [AMP_W-1:0]           af_q;
  logic [KW-1:0]              k;
  logic [KW-1:0]              n_active;
  logic [KIW-1:0]             kidx;
  logic [MW-1:0]              m;
  logic [DW-1:0]              d;
  logic [TOTAL_W-1:0]         total;
  logic [TOTAL_W-1:0]         rem;
  logic [TOTAL_W-1:0]         den;
  logic [RECIP_W-1:0]         dq;
  logic [CW-1:0]              cnt;
  logic [PHASE_W-1:0]         inc;
  logic [PHASE_W-1:0]         step;
  logic [IW-1:0]              idx_q;
  logic [IW-1:0]              idx_next;
  logic [IW-1:0]              rom_addr;
  logic [15:0]                frac;
  logic signed [SAMPLE_W-1:0] sa;
  logic signed [SAMPLE_W-1:0] rom_q;
  logic signed [ACC_W-1:0]    acc;
  logic signed [SAMPLE_W-1:0] res;
  logic signed [SAMPLE_W-1:0] sample_q;

  // memories
  logic [PHASE_W-1:0] phase_mem [MAX_HARMONICS];
  logic [PHASE_W-1:0] phase_q;
  logic [RECIP_W-1:0] weight_mem [MAX_HARMONICS];
  logic [RECIP_W-1:0] wq;
  logic               ph_we;
  logic               w_we;
  logic [RECIP_W-1:0] w_wdata;

  // shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;

  // divider step
  logic [TOTAL_W:0]   div_t;
  logic               div_ge;
  logic [TOTAL_W:0]   div_diff;
  logic [TOTAL_W-1:0] rem_next;
  logic [RECIP_W-1:0] dq_next;

  logic                      odd;
  logic [PHASE_W-1:0]        ph;
  logic signed [SAMPLE_W:0]  diff;
  logic signed [MUL_P_W-1:0] interp;
  logic signed [SAMPLE_W:0]  sine_w;
  logic signed [SAMPLE_W-1:0] sine;
  logic signed [MUL_P_W-1:0] v_amp;

  // ---------------- register port ----------------
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;
  assign cfg_idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign rebuild_wr = cfg_wr && (cfg_idx inside {REG_WAVEFORM, REG_HCOUNT});

  always_ff @(posedge clk) begin
    if (rst) begin
      base_inc <= '0;
      waveform <= WAVE_SQUARE;
      hcount   <= HCOUNT_W'(1);
      gain     <= 16'h8000;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BASE_INC: base_inc <= pwdata;
        REG_WAVEFORM: waveform <= wave_t'(pwdata[WAVE_W-1:0]);
        REG_HCOUNT:   hcount   <= pwdata[HCOUNT_W-1:0];
        REG_GAIN:     gain     <= pwdata[GAIN_W-1:0];
        default:      base_inc <= base_inc;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BASE_INC: prdata = base_inc;
      REG_WAVEFORM: prdata = APB_DATA_W'(waveform);
      REG_HCOUNT:   prdata = APB_DATA_W'(hcount);
      REG_GAIN:     prdata = APB_DATA_W'(gain);
      default:      prdata = '0;
    endcase
  end

  // ---------------- combinational helpers ----------------
  always_comb begin
    if (HW'(hcount) > HW'(MAX_HARMONICS)) begin
      n_active = KW'(MAX_HARMONICS);
    end else begin
      n_active = KW'(hcount);
    end
  end

  assign kidx     = k[KIW-1:0];
  assign odd      = waveform inside {WAVE_TRIANGLE, WAVE_SQUARE};
  assign ph       = phase_valid[kidx] ? phase_q : phase_start;
  assign idx_next = (idx_q == IW'(SINE_TABLE_SIZE - 1)) ? '0 : idx_q + 1'b1;
  assign diff     = (SAMPLE_W + 1)'(rom_q) - (SAMPLE_W + 1)'(sa);
  assign interp   = prod >>> 16;
  assign sine_w   = (SAMPLE_W + 1)'(sa) + (SAMPLE_W + 1)'(interp);
  assign sine     = sine_w[SAMPLE_W-1:0];
  assign v_amp    = prod >>> 15;

  assign div_t    = {rem, dq[RECIP_W-1]};
  assign div_diff = div_t - {1'b0, den};
  assign div_ge   = div_t >= {1'b0, den};
  assign rem_next = div_ge ? div_diff[TOTAL_W-1:0] : div_t[TOTAL_W-1:0];
  assign dq_next  = {dq[RECIP_W-2:0], div_ge};

  always_comb begin
    case (state)
      ST_H_ROMA: rom_addr = prod[32 +: IW];
      ST_H_ROMB: rom_addr = idx_next;
      default:   rom_addr = idx_q;
    endcase
  end

  always_comb begin
    case (state)
      ST_FUND: begin
        mul_a = MUL_A_W'(base_inc);
        mul_b = MUL_B_W'(ff_q);
      end
      ST_H_PMUL: begin
        mul_a = MUL_A_W'(ph);
        mul_b = MUL_B_W'(SINE_TABLE_SIZE);
      end
      ST_H_IMUL: begin
        mul_a = MUL_A_W'(diff);
        mul_b = MUL_B_W'(frac);
      end
      ST_H_WMUL: begin
        mul_a = MUL_A_W'(sine);
        mul_b = MUL_B_W'(wq[WEIGHT_W-1:0]);
      end
      ST_O_SCALE: begin
        mul_a = MUL_A_W'(acc >>> 24);
        mul_b = MUL_B_W'(gain);
      end
      ST_O_GAIN: begin
        mul_a = MUL_A_W'(v_amp);
        mul_b = MUL_B_W'(af_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // ---------------- memories ----------------
  assign ph_we   = (state == ST_H_PMUL);
  assign w_we    = (state == ST_W_STORE1) || (state == ST_W_STORE2);
  assign w_wdata = (state == ST_W_STORE1) ? dq : RECIP_W'(dq[WEIGHT_W-1:0]);

  always_ff @(posedge clk) begin
    if (ph_we) begin
      phase_mem[kidx] <= ph + inc;
    end
    phase_q <= phase_mem[kidx];
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      weight_mem[kidx] <= w_wdata;
    end
    wq <= weight_mem[kidx];
  end

  always_ff @(posedge clk) begin
    rom_q <= SINE_ROM[rom_addr];
  end

  // ---------------- sequencer ----------------
  assign ctrl.ready   = (state == ST_IDLE) && !dirty;
  assign audio.valid  = out_valid;
  assign audio.sample = sample_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      dirty       <= 1'b1;
      out_valid   <= 1'b0;
      phase_valid <= '0;
      phase_start <= '0;
    end else begin
      // the finishing state reloads the output register itself
      if (audio.ready && (state != ST_O_DONE)) begin
        out_valid <= 1'b0;
      end
      // waveform or count changed: weights are stale, restart any rebuild
      if (rebuild_wr && (state inside {[ST_W_INIT:ST_W_STORE2]})) begin
        state <= ST_W_INIT;
      end else begin
        if (rebuild_wr) begin
          dirty <= 1'b1;
        end
        case (state)
          ST_IDLE: begin
            if (dirty) begin
              state <= ST_W_INIT;
            end else if (ctrl.valid) begin
              ff_q <= ctrl.freq_factor;
              af_q <= ctrl.amp_factor;
              if (ctrl.restart) begin
                phase_start <= (waveform == WAVE_TRIANGLE) ? QUARTER_TURN : '0;
                phase_valid <= '0;
              end
              state <= ST_FUND;
            end
          end

          // weight rebuild, pass 1: reciprocals and their sum
          ST_W_INIT: begin
            k     <= '0;
            m     <= MW'(1);
            d     <= DW'(1);
            total <= '0;
            if (n_active == '0) begin
              dirty <= 1'b0;
              state <= ST_IDLE;
            end else begin
              state <= ST_W_LOAD1;
            end
          end
          ST_W_LOAD1: begin
            rem   <= '0;
            dq    <= {1'b1, {(RECIP_W - 1){1'b0}}};
            den   <= (waveform == WAVE_TRIANGLE) ? TOTAL_W'(d) : TOTAL_W'(m);
            cnt   <= CW'(RECIP_W);
            state <= ST_W_DIV1;
          end
          ST_W_DIV1: begin
            rem <= rem_next;
            dq  <= dq_next;
            cnt <= cnt - 1'b1;
            if (cnt == CW'(1)) begin
              state <= ST_W_STORE1;
            end
          end
          ST_W_STORE1: begin
            total <= total + TOTAL_W'(dq);
            m     <= odd ? m + MW'(2) : m + MW'(1);
            // (m+2)^2 = m^2 + 4m + 4
            d     <= d + DW'({m, 2'b00}) + DW'(4);
            if ((k + 1'b1) == n_active) begin
              k     <= '0;
              state <= ST_W_READ2;
            end else begin
              k     <= k + 1'b1;
              state <= ST_W_LOAD1;
            end
          end

          // pass 2: normalize, w = r*2^24 / total
          ST_W_READ2: begin
            state <= ST_W_LOAD2;
          end
          ST_W_LOAD2: begin
            rem   <= TOTAL_W'(wq >> 1);
            dq    <= {wq[0], {(RECIP_W - 1){1'b0}}};
            den   <= total;
            cnt   <= CW'(WEIGHT_W);
            state <= ST_W_DIV2;
          end
          ST_W_DIV2: begin
            rem <= rem_next;
            dq  <= dq_next;
            cnt <= cnt - 1'b1;
            if (cnt == CW'(1)) begin
              state <= ST_W_STORE2;
            end
          end
          ST_W_STORE2: begin
            if ((k + 1'b1) == n_active) begin
              dirty <= 1'b0;
              state <= ST_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= ST_W_READ2;
            end
          end

          // tick
          ST_FUND: begin
            acc   <= '0;
            k     <= '0;
            state <= ST_FUND_LATCH;
          end
          ST_FUND_LATCH: begin
            inc  <= prod[12 +: PHASE_W];
            step <= odd ? {prod[12 +: PHASE_W-1], 1'b0} : prod[12 +: PHASE_W];
            if (n_active == '0) begin
              state <= ST_O_SCALE;
            end else begin
              state <= ST_H_READ;
            end
          end
          ST_H_READ: begin
            state <= ST_H_PMUL;
          end
          ST_H_PMUL: begin
            phase_valid[kidx] <= 1'b1;
            state             <= ST_H_ROMA;
          end
          ST_H_ROMA: begin
            idx_q <= prod[32 +: IW];
            frac  <= prod[31:16];
            state <= ST_H_ROMB;
          end
          ST_H_ROMB: begin
            sa    <= rom_q;
            state <= ST_H_IMUL;
          end
          ST_H_IMUL: begin
            state <= ST_H_WMUL;
          end
          ST_H_WMUL: begin
            state <= ST_H_ACC;
          end
          ST_H_ACC: begin
            if (waveform == WAVE_SAW_RISE) begin
              acc <= acc - ACC_W'(prod);
            end else begin
              acc <= acc + ACC_W'(prod);
            end
            inc <= inc + step;
            k   <= k + 1'b1;
            if ((k + 1'b1) == n_active) begin
              state <= ST_O_SCALE;
            end else begin
              state <= ST_H_READ;
            end
          end
          ST_O_SCALE: begin
            state <= ST_O_GAIN;
          end
          ST_O_GAIN: begin
            state <= ST_O_AMP;
          end
          ST_O_AMP: begin
            if (v_amp > MUL_P_W'(SAMPLE_MAX)) begin
              res <= SAMPLE_MAX;
            end else if (v_amp < MUL_P_W'(SAMPLE_MIN)) begin
              res <= SAMPLE_MIN;
            end else begin
              res <= v_amp[SAMPLE_W-1:0];
            end
            state <= ST_O_DONE;
          end
          ST_O_DONE: begin
            if (!out_valid || audio.ready) begin
              out_valid <= 1'b1;
              sample_q  <= res;
              state     <= ST_IDLE;
            end
          end
          default: begin
            state <= ST_IDLE;
          end
        endcase
      end
    end
  end

  // ---------------- assertions ----------------
  `AHOB_ASSERT_IMPL(a_harm_in_range, clk, rst, state == ST_H_READ, k < n_active, "harmonic index past active count")
  `AHOB_ASSERT_NEXT(a_no_early_result, clk, rst, ctrl.valid && ctrl.ready && !audio.valid, !audio.valid, "result raised right after accepting a tick")
  `AHOB_ASSERT_IMPL(a_div_rem, clk, rst, state == ST_W_DIV1 || state == ST_W_DIV2, rem < den, "divider remainder not below divisor")

endmodule
